### hw/rtl/dmce_pkg.sv
// Shared types, constants and the value scaling function of the deadband
// MIDI control change encoder. No dependencies.
package dmce_pkg;

   localparam int NUM_CHANNELS = 12;
   localparam int CH_W         = 4;
   localparam int SAMPLE_W     = 12;
   localparam int STORE_W      = 13;
   localparam int BYTE_W       = 8;
   localparam int VALUE_W      = 7;
   localparam int PROD_W       = 19;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 12;
   localparam int SAMPLE_FULL  = 4095;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHANGE_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STATUS_BYTE      = 1'd1;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd100;
   localparam logic [BYTE_W-1:0]   STATUS_RESET    = 8'd176;
   localparam logic [STORE_W-1:0]  STORE_RESET     = 13'h1FFF;

   typedef struct packed {
      logic                en;
      logic [CH_IDX_W-1:0] idx;
      logic [STORE_W-1:0]  data;
   } wr_port_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  status;
      logic [CH_W-1:0]    ctrl;
      logic [VALUE_W-1:0] value;
   } msg_type;

   typedef enum logic [2:0] {
      PH_STATUS = 3'b001,
      PH_CTRL   = 3'b010,
      PH_VALUE  = 3'b100
   } phase_type;

   // Computes sample * 126 / 4095 + 1. The quotient by 4095 is estimated with
   // a shift and corrected by one compare and subtract.
   function automatic logic [VALUE_W-1:0] scale_value(input logic [SAMPLE_W-1:0] s);
      logic [PROD_W-1:0]  prod;
      logic [VALUE_W-1:0] q_est;
      logic [PROD_W:0]    rem;
      prod  = {s, 7'b0} - {6'b0, s, 1'b0};
      q_est = prod[PROD_W-1:SAMPLE_W];
      rem   = {1'b0, prod} - {1'b0, q_est, 12'b0} + {13'b0, q_est};
      if (rem >= (PROD_W+1)'(SAMPLE_FULL)) begin
         q_est = q_est + 7'd1;
      end
      return q_est + 7'd1;
   endfunction

endpackage

### hw/rtl/dmce_state_mem.sv
// Per-channel store of the last reported sample, with registered read,
// write-to-read forwarding and reset-valid bits. Depends on dmce_pkg.
module dmce_state_mem
   import dmce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [CH_IDX_W-1:0] rd_idx,
   input  wr_port_type         wr,
   output logic [STORE_W-1:0]  rd_data
);

   logic [STORE_W-1:0]      mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [NUM_CHANNELS-1:0] valid_in;
   logic [STORE_W-1:0]      mem_rd_ff;
   logic                    rd_valid_ff;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic [STORE_W-1:0]      fwd_data_ff;

   assign fwd_in = wr.en && (wr.idx == rd_idx);

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
            fwd_ff      <= fwd_in;
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (rd_valid_ff ? mem_rd_ff : STORE_RESET);

`ifndef SYNTHESIS
   a_wr_idx_range: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ({1'b0, wr.idx} < (CH_IDX_W+1)'(NUM_CHANNELS)))
      else $error("state write beyond channel count");
   a_wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> valid_ff[$past(wr.idx)])
      else $error("written entry not marked valid");
`endif

endmodule

### hw/rtl/dmce_msg_ser.sv
// Output register that sends one three-byte control change message one
// byte per item. Depends on dmce_pkg.
module dmce_msg_ser
   import dmce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  msg_type           msg,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte
);

   logic      valid_ff;
   logic      valid_in;
   phase_type phase_ff;
   phase_type phase_in;
   msg_type   msg_ff;
   logic      take;

   assign take  = valid_ff && !rsp_stall;
   assign ready = !valid_ff || (take && (phase_ff == PH_VALUE));

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_STATUS: phase_in = PH_CTRL;
            PH_CTRL:   phase_in = PH_VALUE;
            PH_VALUE: begin
               phase_in = PH_STATUS;
               valid_in = load;
            end
            default:   phase_in = PH_STATUS;
         endcase
      end else if (!valid_ff && load) begin
         valid_in = 1'b1;
         phase_in = PH_STATUS;
      end
   end

   always_ff @(posedge clock) begin
      if (load && ready) begin
         msg_ff <= msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_STATUS;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_STATUS: rsp_out_byte = msg_ff.status;
         PH_CTRL:   rsp_out_byte = BYTE_W'(msg_ff.ctrl);
         PH_VALUE:  rsp_out_byte = BYTE_W'(msg_ff.value);
         default:   rsp_out_byte = msg_ff.status;
      endcase
   end

   assign rsp_valid     = valid_ff;
   assign rsp_last_byte = (phase_ff == PH_VALUE);

`ifndef SYNTHESIS
   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      load |-> ready)
      else $error("message loaded while serializer busy");
   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && (phase_ff == PH_VALUE) && !load) |=> !rsp_valid)
      else $error("item shown after last byte with nothing loaded");
`endif

endmodule

### hw/rtl/deadband_midi_cc_encoder_unit.sv
// Top level of the deadband MIDI control change encoder: input stage,
// deadband compare and scaling. Depends on dmce_pkg, dmce_state_mem, dmce_msg_ser.
//
//   Channel  Ports                                   Direction  Item
//   req      req_valid req_stall req_channel/sample  in         one sample
//   rsp      rsp_valid rsp_stall rsp_out_byte/last   out        one message byte
//   csr      csr_wr_en csr_index csr_wdata           in         one register write
//
// An item that sends no message leaves the input stage at once; a triggering item
// leaves once the output serializer takes its message, sent one byte per rsp item.
// The item is registered in the input stage, then its message in the serializer.
// Synchronous reset clears the per-channel valid bits, so every channel reads -1;
// there is no clearing pass.
// A stall on rsp holds the message and backs up into req_stall.
module deadband_midi_cc_encoder_unit
   import dmce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CH_W-1:0]       req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic                  rsp_last_byte,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SAMPLE_W-1:0] threshold_ff;
   logic [BYTE_W-1:0]   status_ff;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_range_ff;
   logic [CH_W-1:0]     s1_ch_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;

   logic                accept;
   logic                in_range;
   logic [STORE_W-1:0]  stored;
   logic signed [STORE_W:0] diff;
   logic [STORE_W:0]    diff_neg;
   logic [STORE_W-1:0]  mag;
   logic                trigger;
   logic                ser_ready;
   logic                load;
   logic                s1_adv;
   wr_port_type         wr;
   msg_type             msg;

   assign accept   = req_valid && !req_stall;
   assign in_range = {1'b0, req_channel} < (CH_W+1)'(NUM_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         status_ff    <= STATUS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANGE_THRESHOLD: threshold_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_STATUS_BYTE:      status_ff    <= csr_wdata[BYTE_W-1:0];
            default:              threshold_ff <= threshold_ff;
         endcase
      end
   end

   dmce_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && in_range),
      .rd_idx  (req_channel[CH_IDX_W-1:0]),
      .wr      (wr),
      .rd_data (stored)
   );

   assign diff     = $signed({2'b00, s1_sample_ff}) - $signed({stored[STORE_W-1], stored});
   assign diff_neg = (STORE_W+1)'(-diff);
   assign mag      = diff[STORE_W] ? diff_neg[STORE_W-1:0] : diff[STORE_W-1:0];
   assign trigger  = s1_valid_ff && s1_range_ff && (mag >= {1'b0, threshold_ff});

   assign load      = trigger && ser_ready;
   assign s1_adv    = s1_valid_ff && (!trigger || ser_ready);
   assign req_stall = s1_valid_ff && !s1_adv;

   assign wr.en   = load;
   assign wr.idx  = s1_ch_ff[CH_IDX_W-1:0];
   assign wr.data = {1'b0, s1_sample_ff};

   assign msg.status = status_ff;
   assign msg.ctrl   = s1_ch_ff;
   assign msg.value  = scale_value(s1_sample_ff);

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff     <= req_channel;
         s1_sample_ff <= req_sample;
         s1_range_ff  <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   dmce_msg_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .msg           (msg),
      .ready         (ser_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

`ifndef SYNTHESIS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (s1_valid_ff && s1_range_ff))
      else $error("state written for an ignored item");
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with an empty stage");
`endif

endmodule
